/* rtl/sstf_pkg.sv */
// Shared types and constants for the SSTF seek distance unit.
// Used by the search cell and the top level; no dependencies.
package sstf_pkg;

    // Fixed field widths of the transfer payloads
    localparam int TRACK_W = 16;
    localparam int SUM_W   = 22;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Parameter defaults
    localparam int DEF_MAX_REQUESTS = 64;
    localparam int DEF_TRACK_BITS   = 16;

    // Register port: byte address width and register word index
    localparam int ADDR_W = 3;
    localparam logic REG_START_TRACK = 1'b0;

    // One input transfer
    typedef struct packed {
        logic [TRACK_W-1:0] track;
        logic               last;
    } req_item_t;

    // One result transfer
    typedef struct packed {
        logic [SUM_W-1:0] total_distance;
        logic             too_many;
    } res_item_t;

    // Control bits of the search wave travelling down the cell row
    typedef struct packed {
        logic valid;
        logic found;
    } wave_ctl_t;

    // Load and mark controls broadcast to every cell
    typedef struct packed {
        logic shift;
        logic clr_en;
    } cell_ctl_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SEARCH,
        ST_FINISH
    } state_t;

endpackage

/* rtl/sstf_seek_distance_unit.sv */
// SSTF seek distance unit: loads a batch of track requests, one per transfer,
// then serves them nearest-first from the configured start track and returns
// the total seek distance. Requests shift into a row of MAX_REQUESTS cells;
// each nearest-request search is a wave that crosses the row one cell per
// cycle. A batch is loaded, then searched wave by wave until a wave finds
// no pending request, before the result is offered; input transfers stall
// during search and while a finished result waits for the receiver to take
// the previous one.
// Depends on sstf_pkg and sstf_cell.
module sstf_seek_distance_unit #(
    parameter int MAX_REQUESTS = sstf_pkg::DEF_MAX_REQUESTS,
    parameter int TRACK_BITS   = sstf_pkg::DEF_TRACK_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sstf_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  sstf_pkg::req_item_t           req,
    output logic                          res_valid,
    input  logic                          res_stall,
    output sstf_pkg::res_item_t           res
);
    import sstf_pkg::*;

    localparam int IDX_W  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);
    localparam int WIDE_W = ((TRACK_BITS > SUM_W) ? TRACK_BITS : SUM_W) + 1;

    // Register port
    logic [TRACK_W-1:0] start_reg;
    logic               cfg_wr;
    logic               cfg_hit;

    // Controller state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [TRACK_BITS-1:0] head_reg, head_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               launch_reg, launch_next;
    logic               res_valid_reg, res_valid_next;
    res_item_t          res_reg, res_next;

    logic               req_acc;
    logic               room;
    logic [WIDE_W-1:0]  sum_wide;
    logic [SUM_W-1:0]   sum_sat;
    cell_ctl_t          cell_ctl;

    // Row links
    logic [TRACK_BITS-1:0] track_link [0:MAX_REQUESTS];
    logic                  pend_link  [0:MAX_REQUESTS];
    wave_ctl_t             wave_link  [0:MAX_REQUESTS];
    logic [TRACK_BITS-1:0] wdist_link [0:MAX_REQUESTS];
    logic [IDX_W-1:0]      widx_link  [0:MAX_REQUESTS];
    logic [TRACK_BITS-1:0] wtrack_link[0:MAX_REQUESTS];

    // Decode register writes and reads
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[ADDR_W-1] == REG_START_TRACK);
    assign cfg_wr  = psel && penable && pwrite && cfg_hit;
    assign prdata  = cfg_hit ? {{(32-TRACK_W){1'b0}}, start_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
        end
        else if (cfg_wr)
        begin
            start_reg <= pwdata[TRACK_W-1:0];
        end
    end

    // Feed new requests and the wave seed into the row
    assign track_link[0]        = TRACK_BITS'(req.track);
    assign pend_link[0]         = 1'b1;
    assign wave_link[MAX_REQUESTS]   = '{valid: launch_reg, found: 1'b0};
    assign wdist_link[MAX_REQUESTS]  = '0;
    assign widx_link[MAX_REQUESTS]   = '0;
    assign wtrack_link[MAX_REQUESTS] = '0;

    genvar k;
    generate
        for (k = 0; k < MAX_REQUESTS; k++)
        begin : g_cell
            sstf_cell #(
                .TRACK_BITS (TRACK_BITS),
                .IDX_W      (IDX_W),
                .CELL_IDX   (k)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (cell_ctl),
                .clr_idx    (widx_link[0]),
                .head       (head_reg),
                .track_in   (track_link[k]),
                .pend_in    (pend_link[k]),
                .track_out  (track_link[k+1]),
                .pend_out   (pend_link[k+1]),
                .wave_in    (wave_link[k+1]),
                .wdist_in   (wdist_link[k+1]),
                .widx_in    (widx_link[k+1]),
                .wtrack_in  (wtrack_link[k+1]),
                .wave_out   (wave_link[k]),
                .wdist_out  (wdist_link[k]),
                .widx_out   (widx_link[k]),
                .wtrack_out (wtrack_link[k])
            );
        end
    endgenerate

    // Saturating add of the found seek length
    always_comb
    begin
        sum_wide = WIDE_W'(sum_reg) + WIDE_W'(wdist_link[0]);
        if (sum_wide > WIDE_W'(SUM_MAX))
        begin
            sum_sat = SUM_MAX;
        end
        else
        begin
            sum_sat = SUM_W'(sum_wide);
        end
    end

    assign req_acc = req_valid && !req_stall;
    assign room    = (count_reg < CNT_W'(MAX_REQUESTS));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (req_acc && req.last)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (wave_link[0].valid && !wave_link[0].found)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        req_stall      = (state_reg != ST_LOAD);
        cell_ctl       = '0;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        head_next      = head_reg;
        sum_next       = sum_reg;
        launch_next    = 1'b0;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (req_acc)
                begin
                    if (room)
                    begin
                        cell_ctl.shift = 1'b1;
                        count_next     = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (req.last)
                    begin
                        head_next   = TRACK_BITS'(start_reg);
                        sum_next    = '0;
                        launch_next = 1'b1;
                    end
                end
            end
            ST_SEARCH:
            begin
                // Serve the winner and launch the next wave
                if (wave_link[0].valid && wave_link[0].found)
                begin
                    sum_next        = sum_sat;
                    head_next       = wtrack_link[0];
                    cell_ctl.clr_en = 1'b1;
                    launch_next     = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_next.total_distance = sum_reg;
                    res_next.too_many       = ovf_reg;
                    res_valid_next          = 1'b1;
                    count_next              = '0;
                    ovf_next                = 1'b0;
                end
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            head_reg      <= '0;
            sum_reg       <= '0;
            launch_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            head_reg      <= head_next;
            sum_reg       <= sum_next;
            launch_reg    <= launch_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* rtl/sstf_cell.sv */
// One cell of the request row: holds a track and its pending mark, shifts
// loads upward, and refines the passing nearest-request search wave.
// Depends on sstf_pkg.
module sstf_cell #(
    parameter int TRACK_BITS = sstf_pkg::DEF_TRACK_BITS,
    parameter int IDX_W      = 6,
    parameter int CELL_IDX   = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sstf_pkg::cell_ctl_t     ctl,
    input  logic [IDX_W-1:0]        clr_idx,
    input  logic [TRACK_BITS-1:0]   head,
    input  logic [TRACK_BITS-1:0]   track_in,
    input  logic                    pend_in,
    output logic [TRACK_BITS-1:0]   track_out,
    output logic                    pend_out,
    input  sstf_pkg::wave_ctl_t     wave_in,
    input  logic [TRACK_BITS-1:0]   wdist_in,
    input  logic [IDX_W-1:0]        widx_in,
    input  logic [TRACK_BITS-1:0]   wtrack_in,
    output sstf_pkg::wave_ctl_t     wave_out,
    output logic [TRACK_BITS-1:0]   wdist_out,
    output logic [IDX_W-1:0]        widx_out,
    output logic [TRACK_BITS-1:0]   wtrack_out
);
    import sstf_pkg::*;

    logic [TRACK_BITS-1:0] track_reg;
    logic                  pend_reg;
    logic                  wvalid_reg;
    logic                  wfound_reg;
    logic [TRACK_BITS-1:0] wdist_reg;
    logic [IDX_W-1:0]      widx_reg;
    logic [TRACK_BITS-1:0] wtrack_reg;

    logic [TRACK_BITS-1:0] seek_len;
    logic                  take;

    // Distance from the head and take decision; strict compare keeps the older request
    always_comb
    begin
        seek_len = (track_reg >= head) ? (track_reg - head) : (head - track_reg);
        take     = pend_reg && (!wave_in.found || (seek_len < wdist_in));
    end

    // Shift in loads, drop the mark of the served request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            pend_reg <= pend_in;
        end
        else if (ctl.clr_en && (clr_idx == IDX_W'(CELL_IDX)))
        begin
            pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            track_reg <= track_in;
        end
    end

    // Advance the search wave by one cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wvalid_reg <= 1'b0;
        end
        else
        begin
            wvalid_reg <= wave_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        wfound_reg <= wave_in.found || pend_reg;
        if (take)
        begin
            wdist_reg  <= seek_len;
            widx_reg   <= IDX_W'(CELL_IDX);
            wtrack_reg <= track_reg;
        end
        else
        begin
            wdist_reg  <= wdist_in;
            widx_reg   <= widx_in;
            wtrack_reg <= wtrack_in;
        end
    end

    assign track_out  = track_reg;
    assign pend_out   = pend_reg;
    assign wave_out   = '{valid: wvalid_reg, found: wfound_reg};
    assign wdist_out  = wdist_reg;
    assign widx_out   = widx_reg;
    assign wtrack_out = wtrack_reg;

endmodule
